>>> rtl/core/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Types and constants shared by the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

	localparam int unsigned ACTION_W  = 2;
	localparam int unsigned REQ_W     = 16;
	localparam int unsigned OFFSET_W  = 12;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned COUNT_W   = 10;
	localparam int unsigned BLOCK_W   = 13;

	localparam logic [COUNT_W-1:0] COUNT_MAX       = 10'd1023;
	localparam logic [BLOCK_W-1:0] BLOCK_BYTES_RST = 13'd32;
	localparam logic [BLOCK_W-1:0] BLOCK_MIN       = 13'd8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_INIT  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 2'd0,
		STS_EMPTY   = 2'd1,
		STS_TOO_BIG = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_FREE,
		ST_INIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [REQ_W-1:0]    request_bytes;
		logic [OFFSET_W-1:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] block_offset;
		logic [COUNT_W-1:0]  blocks_free;
	} rsp_t;

endpackage

>>> rtl/core/fbfl_stream_if.sv
// ----------------------------------------------------------------------------
// fbfl_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface fbfl_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Free list pool of equal blocks over one page, links held in a sync memory.
// ----------------------------------------------------------------------------
// One item is worked at a time and each gives one result item. Allocate, free
// and the unused action each pass through their own state before the next
// accept: an allocate reads the head block's link from the link memory into a
// register at accept before it can pop, a free writes the new link in the free
// state. Initialize walks the page one block per cycle through the single link
// memory write port, then loads the head and goes to the done state. The
// result sits in an output register, so a stalled consumer holds the block
// only when a new result is ready to be loaded. No clearing pass after reset:
// link entries are defined once written by initialize or free.
module fixed_block_free_list_allocator #(
	parameter int unsigned PAGE_BYTES = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fbfl_pkg::BLOCK_W-1:0]     cfg_wr_data,
	fbfl_stream_if.sink                      req,
	fbfl_stream_if.source                    rsp
);

	localparam int unsigned DEPTH = PAGE_BYTES / 8;
	localparam int unsigned IW    = $clog2(DEPTH);
	localparam int unsigned OW    = $clog2(PAGE_BYTES) + 1;
	localparam int unsigned SW    = ((OW > fbfl_pkg::BLOCK_W) ? OW : fbfl_pkg::BLOCK_W) + 2;
	localparam logic [SW-1:0] PAGE_SW = SW'(PAGE_BYTES);
	localparam logic [OW-1:0] NULL_OW = OW'(PAGE_BYTES);
	localparam logic [SW-1:0] DEPTH_SW = SW'(DEPTH);

	// byte offset to link entry, wrapping like the page depth
	function automatic logic [IW-1:0] link_idx(input logic [SW-1:0] off);
		logic [SW-1:0] sh;
		sh = off >> 3;
		if (sh >= DEPTH_SW) begin
			sh = sh - DEPTH_SW;
		end
		return sh[IW-1:0];
	endfunction

	fbfl_pkg::state_t                 state_q, state_d;
	logic [fbfl_pkg::BLOCK_W-1:0]     block_bytes_q;
	logic [OW-1:0]                    head_q;
	logic [fbfl_pkg::COUNT_W-1:0]     free_q;
	logic [SW-1:0]                    off_q;

	logic [fbfl_pkg::REQ_W-1:0]       req_bytes_q;
	logic [fbfl_pkg::OFFSET_W-1:0]    foff_q;

	logic [OW-1:0]                    link_mem [DEPTH];
	logic [OW-1:0]                    link_rd_q;

	logic                             rsp_valid_q;
	fbfl_pkg::rsp_t                   rsp_data_q;

	logic                             slot_free;
	logic                             accept;
	logic [fbfl_pkg::BLOCK_W-1:0]     bs13;
	logic [SW-1:0]                    bs;
	logic [SW-1:0]                    next_off;
	logic [SW-1:0]                    next2_off;
	logic [SW-1:0]                    foff_sw;
	logic [fbfl_pkg::COUNT_W-1:0]     free_inc;

	logic                             res_load;
	fbfl_pkg::rsp_t                   res_d;
	logic                             mem_we;
	logic [IW-1:0]                    mem_waddr;
	logic [OW-1:0]                    mem_wdata;
	logic                             head_we;
	logic [OW-1:0]                    head_d;
	logic                             free_we;
	logic [fbfl_pkg::COUNT_W-1:0]     free_d;
	logic                             init_start;
	logic                             off_step;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_comb begin
		bs13 = {block_bytes_q[fbfl_pkg::BLOCK_W-1:3], 3'b000};
		if (bs13 == '0) begin
			bs13 = fbfl_pkg::BLOCK_MIN;
		end
	end

	assign bs        = SW'(bs13);
	assign next_off  = off_q + bs;
	assign next2_off = next_off + bs;
	assign foff_sw   = SW'(foff_q);
	assign free_inc  = (free_q == fbfl_pkg::COUNT_MAX) ? free_q : free_q + 1'b1;

	// next state and datapath controls
	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		res_load   = 1'b0;
		res_d      = '0;
		mem_we     = 1'b0;
		mem_waddr  = link_idx(off_q);
		mem_wdata  = NULL_OW;
		head_we    = 1'b0;
		head_d     = head_q;
		free_we    = 1'b0;
		free_d     = free_q;
		init_start = 1'b0;
		off_step   = 1'b0;
		unique case (state_q)
			fbfl_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					unique case (fbfl_pkg::action_t'(req.data.action))
						fbfl_pkg::ACT_ALLOC: state_d = fbfl_pkg::ST_ALLOC;
						fbfl_pkg::ACT_FREE:  state_d = fbfl_pkg::ST_FREE;
						fbfl_pkg::ACT_INIT: begin
							state_d    = fbfl_pkg::ST_INIT;
							init_start = 1'b1;
						end
						default:             state_d = fbfl_pkg::ST_DONE;
					endcase
				end
			end
			fbfl_pkg::ST_ALLOC: begin
				if (slot_free) begin
					res_load          = 1'b1;
					res_d.blocks_free = free_q;
					priority if (free_q == '0 || SW'(head_q) >= PAGE_SW) begin
						res_d.status = fbfl_pkg::STS_EMPTY;
					end else if (req_bytes_q > fbfl_pkg::REQ_W'(bs13)) begin
						res_d.status = fbfl_pkg::STS_TOO_BIG;
					end else begin
						res_d.status       = fbfl_pkg::STS_OK;
						res_d.block_offset = fbfl_pkg::OFFSET_W'(head_q);
						res_d.blocks_free  = free_q - 1'b1;
						head_we            = 1'b1;
						head_d             = link_rd_q;
						free_we            = 1'b1;
						free_d             = free_q - 1'b1;
					end
					state_d = fbfl_pkg::ST_IDLE;
				end
			end
			fbfl_pkg::ST_FREE: begin
				if (slot_free) begin
					res_load          = 1'b1;
					res_d.status      = fbfl_pkg::STS_OK;
					res_d.blocks_free = free_q;
					if (foff_sw < PAGE_SW) begin
						mem_we            = 1'b1;
						mem_waddr         = link_idx(foff_sw);
						mem_wdata         = head_q;
						head_we           = 1'b1;
						head_d            = OW'(foff_q);
						free_we           = 1'b1;
						free_d            = free_inc;
						res_d.blocks_free = free_inc;
					end
					state_d = fbfl_pkg::ST_IDLE;
				end
			end
			fbfl_pkg::ST_INIT: begin
				// one block link per cycle, last whole block links to null
				if (next_off <= PAGE_SW) begin
					mem_we    = 1'b1;
					mem_wdata = (next2_off <= PAGE_SW) ? next_off[OW-1:0] : NULL_OW;
					off_step  = 1'b1;
					free_we   = 1'b1;
					free_d    = free_inc;
				end else begin
					head_we = 1'b1;
					head_d  = (free_q != '0) ? '0 : NULL_OW;
					state_d = fbfl_pkg::ST_DONE;
				end
			end
			fbfl_pkg::ST_DONE: begin
				if (slot_free) begin
					res_load          = 1'b1;
					res_d.status      = fbfl_pkg::STS_OK;
					res_d.blocks_free = free_q;
					state_d           = fbfl_pkg::ST_IDLE;
				end
			end
			default: state_d = fbfl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fbfl_pkg::ST_IDLE;
			block_bytes_q <= fbfl_pkg::BLOCK_BYTES_RST;
			head_q        <= NULL_OW;
			free_q        <= '0;
			off_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				block_bytes_q <= cfg_wr_data;
			end
			if (head_we) begin
				head_q <= head_d;
			end
			if (init_start) begin
				free_q <= '0;
			end else if (free_we) begin
				free_q <= free_d;
			end
			if (init_start) begin
				off_q <= '0;
			end else if (off_step) begin
				off_q <= next_off;
			end
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item payload and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_bytes_q <= req.data.request_bytes;
			foff_q      <= req.data.free_offset;
		end
		if (res_load) begin
			rsp_data_q <= res_d;
		end
	end

	// link memory, head entry read on every accepted item
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			link_rd_q <= link_mem[link_idx(SW'(head_q))];
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	a_alloc_goes_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.data.action == fbfl_pkg::ACT_ALLOC |=> state_q == fbfl_pkg::ST_ALLOC)
		else $error("allocate item did not enter the link read state");

	a_refused_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_data_q.status != fbfl_pkg::STS_OK |->
			rsp_data_q.block_offset == '0)
		else $error("refused allocate reports a block offset");

	a_refused_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fbfl_pkg::ST_ALLOC && res_load && res_d.status != fbfl_pkg::STS_OK |=>
			$stable(free_q) && $stable(head_q))
		else $error("refused allocate changed the pool");

	a_accept_only_idle_slot: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !res_load || state_q == fbfl_pkg::ST_FREE
			|| state_q == fbfl_pkg::ST_ALLOC || state_q == fbfl_pkg::ST_DONE)
		else $error("result loaded in an unexpected state after accept");

endmodule
